// File: design/lkt_pkg.sv
`default_nettype none

package lkt_pkg;

    // Table geometry
    localparam int ENTRIES    = 16;
    localparam int STAMP_BITS = 64;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    // Fixed field widths
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;
    localparam int OUTC_W  = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Reported count saturates here
    localparam int OUT_CNT_MAX = 31;
    localparam int CAP_RESET   = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 3'd0,
        MODE_SET    = 3'd1,
        MODE_INVAL  = 3'd2,
        MODE_GROUP  = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_en;
        logic commit;
    } lkt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } lkt_status_t;

endpackage

`default_nettype wire

// File: design/lkt_ctrl.sv
`default_nettype none

module lkt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lkt_pkg::lkt_status_t status,
    output lkt_pkg::lkt_cmd_t        cmd
);
    import lkt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.scan_en = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/lkt_datapath.sv
`default_nettype none

module lkt_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lkt_pkg::lkt_cmd_t              cmd,
    output lkt_pkg::lkt_status_t                status,
    input  wire logic [lkt_pkg::MODE_W-1:0]     mode,
    input  wire logic [lkt_pkg::KEY_W-1:0]      group_id,
    input  wire logic [lkt_pkg::KEY_W-1:0]      name_id,
    input  wire logic [lkt_pkg::VALUE_W-1:0]    value_in,
    input  wire logic                           cfg_write,
    input  wire logic [lkt_pkg::CAP_W-1:0]      cfg_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                hit,
    output logic [lkt_pkg::VALUE_W-1:0]         value_out,
    output logic [lkt_pkg::OUTC_W-1:0]          entry_count,
    output logic                                evicted
);
    import lkt_pkg::*;

    // Entry storage
    logic [KEY_W-1:0]      group_mem [ENTRIES];
    logic [KEY_W-1:0]      name_mem  [ENTRIES];
    logic [VALUE_W-1:0]    value_mem [ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [STAMP_BITS-1:0] ctr_reg;
    logic [CAP_W-1:0]      capacity_reg;

    // Captured request
    logic [MODE_W-1:0]  mode_reg;
    logic [KEY_W-1:0]   grp_reg;
    logic [KEY_W-1:0]   nm_reg;
    logic [VALUE_W-1:0] val_reg;

    // Scan pipeline
    logic [CNT_W-1:0]      iss_reg;
    logic                  rd_act_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [KEY_W-1:0]      rd_group_reg;
    logic [KEY_W-1:0]      rd_name_reg;
    logic [VALUE_W-1:0]    rd_value_reg;
    logic [STAMP_BITS-1:0] rd_stamp_reg;

    // Scan results
    logic                  found_reg;
    logic [IDX_W-1:0]      fidx_reg;
    logic [VALUE_W-1:0]    fval_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  old_found_reg;
    logic [IDX_W-1:0]      old_idx_reg;
    logic [STAMP_BITS-1:0] old_stamp_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [VALUE_W-1:0]    value_out_reg;
    logic [OUTC_W-1:0]     entry_count_reg;
    logic                  evicted_reg;

    logic                  issue;
    logic [IDX_W-1:0]      iss_idx;
    logic                  rd_v;
    logic                  key_eq;
    logic                  grp_eq;
    logic                  grp_clr;

    // Commit decode
    logic [STAMP_BITS-1:0] ns;
    logic [CMP_W-1:0]      cap_eff;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      cnt_after_ext;
    logic [CNT_W-1:0]      cnt_after;
    logic [IDX_W-1:0]      wr_idx;
    logic                  wr_key;
    logic                  wr_value;
    logic                  wr_stamp;
    logic                  ctr_upd;
    logic                  set_valid;
    logic                  clr_valid;
    logic                  clr_all;
    logic                  o_hit;
    logic [VALUE_W-1:0]    o_val;
    logic                  o_ev;

    assign issue   = cmd.scan_en && (iss_reg < CNT_W'(ENTRIES));
    assign iss_idx = iss_reg[IDX_W-1:0];
    assign rd_v    = valid_reg[rd_idx_reg];
    assign key_eq  = (rd_group_reg == grp_reg) && (rd_name_reg == nm_reg);
    assign grp_eq  = (rd_group_reg == grp_reg);
    assign grp_clr = rd_act_reg && rd_v && grp_eq && (mode_reg == MODE_GROUP);

    assign status.scan_done = rd_act_reg && (rd_idx_reg == IDX_W'(ENTRIES - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    // Hold capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(CAP_RESET);
        end
        else if (cfg_write)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // Capture request on input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            grp_reg  <= group_id;
            nm_reg   <= name_id;
            val_reg  <= value_in;
        end
    end

    // Advance issue counter and read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg    <= '0;
            rd_act_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            iss_reg    <= '0;
            rd_act_reg <= 1'b0;
        end
        else
        begin
            rd_act_reg <= issue;
            rd_idx_reg <= iss_idx;
            if (issue)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
        end
    end

    // Read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_group_reg <= group_mem[iss_idx];
            rd_name_reg  <= name_mem[iss_idx];
            rd_value_reg <= value_mem[iss_idx];
            rd_stamp_reg <= stamp_mem[iss_idx];
        end
    end

    // Track first match, first free slot and oldest stamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
        end
        else if (rd_act_reg)
        begin
            if (rd_v && key_eq && !found_reg)
            begin
                found_reg <= 1'b1;
                fidx_reg  <= rd_idx_reg;
                fval_reg  <= rd_value_reg;
            end
            if (!rd_v && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
            if (rd_v && (!old_found_reg || (rd_stamp_reg < old_stamp_reg)))
            begin
                old_found_reg <= 1'b1;
                old_idx_reg   <= rd_idx_reg;
                old_stamp_reg <= rd_stamp_reg;
            end
        end
    end

    // Decode the commit of one operation
    always_comb
    begin
        ns        = ctr_reg + 1'b1;
        cap_eff   = (CMP_W'(capacity_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                              : CMP_W'(capacity_reg);
        cnt_ext   = CMP_W'(count_reg);
        cnt_after = count_reg;
        wr_idx    = fidx_reg;
        wr_key    = 1'b0;
        wr_value  = 1'b0;
        wr_stamp  = 1'b0;
        ctr_upd   = 1'b0;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        clr_all   = 1'b0;
        o_hit     = 1'b0;
        o_val     = '0;
        o_ev      = 1'b0;
        case (mode_reg)
            MODE_LOOKUP:
            begin
                if (found_reg)
                begin
                    wr_stamp = 1'b1;
                    ctr_upd  = 1'b1;
                    o_hit    = 1'b1;
                    o_val    = fval_reg;
                end
            end
            MODE_SET:
            begin
                ctr_upd = 1'b1;
                if (found_reg)
                begin
                    wr_value = 1'b1;
                    wr_stamp = 1'b1;
                end
                else if (cnt_ext < cap_eff)
                begin
                    wr_idx    = free_idx_reg;
                    wr_key    = 1'b1;
                    wr_value  = 1'b1;
                    wr_stamp  = 1'b1;
                    set_valid = 1'b1;
                    cnt_after = count_reg + 1'b1;
                end
                else
                begin
                    o_ev = 1'b1;
                    if (old_found_reg && !(ns < old_stamp_reg))
                    begin
                        wr_idx   = old_idx_reg;
                        wr_key   = 1'b1;
                        wr_value = 1'b1;
                        wr_stamp = 1'b1;
                    end
                end
            end
            MODE_INVAL:
            begin
                if (found_reg)
                begin
                    clr_valid = 1'b1;
                    cnt_after = count_reg - 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                clr_all   = 1'b1;
                cnt_after = '0;
            end
            default:
            begin
            end
        endcase
        cnt_after_ext = CMP_W'(cnt_after);
    end

    // Write entry fields on commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (wr_key)
            begin
                group_mem[wr_idx] <= grp_reg;
                name_mem[wr_idx]  <= nm_reg;
            end
            if (wr_value)
            begin
                value_mem[wr_idx] <= val_reg;
            end
            if (wr_stamp)
            begin
                stamp_mem[wr_idx] <= ns;
            end
        end
    end

    // Update valid bits, count and access counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            ctr_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= cnt_after;
            if (ctr_upd)
            begin
                ctr_reg <= ns;
            end
            if (clr_all)
            begin
                valid_reg <= '0;
            end
            else if (set_valid)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (clr_valid)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
        else if (grp_clr)
        begin
            valid_reg[rd_idx_reg] <= 1'b0;
            count_reg             <= count_reg - 1'b1;
        end
    end

    // Hold result until the output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg       <= o_hit;
            value_out_reg <= o_val;
            evicted_reg   <= o_ev;
            if (cnt_after_ext > CMP_W'(OUT_CNT_MAX))
            begin
                entry_count_reg <= OUTC_W'(OUT_CNT_MAX);
            end
            else
            begin
                entry_count_reg <= cnt_after_ext[OUTC_W-1:0];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign value_out   = value_out_reg;
    assign entry_count = entry_count_reg;
    assign evicted     = evicted_reg;

endmodule

`default_nettype wire

// File: design/lru_keyed_table_with_group_invalidate.sv
`default_nettype none

// Fully associative keyed table of 16 entries with least-recently-used
// replacement. Each operation (lookup, set, invalidate key, invalidate group,
// clear) is accepted on in_valid/in_ready and answers with exactly one result
// carrying hit, value_out, the entry count after the operation and an eviction
// flag. Every operation scans all entries through the single read port of the
// entry store, one entry per cycle, then commits its write-back; a new item
// is taken only after the previous one has committed. A finished result waits
// in an output register, and a new item is taken while it waits; the commit of
// that next item holds until the waiting result leaves. The capacity register
// is written through cfg_valid/cfg_ready; the user must write it only while
// the table is idle, which the block itself does not enforce. It resets to
// 16 and values above the entry count act as the entry count.
module lru_keyed_table_with_group_invalidate (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lkt_pkg::MODE_W-1:0]     mode,
    input  wire logic [lkt_pkg::KEY_W-1:0]      group_id,
    input  wire logic [lkt_pkg::KEY_W-1:0]      name_id,
    input  wire logic [lkt_pkg::VALUE_W-1:0]    value_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                hit,
    output logic [lkt_pkg::VALUE_W-1:0]         value_out,
    output logic [lkt_pkg::OUTC_W-1:0]          entry_count,
    output logic                                evicted,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lkt_pkg::CAP_W-1:0]      cfg_data
);
    import lkt_pkg::*;

    lkt_cmd_t    cmd;
    lkt_status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    lkt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lkt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .group_id    (group_id),
        .name_id     (name_id),
        .value_in    (value_in),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .value_out   (value_out),
        .entry_count (entry_count),
        .evicted     (evicted)
    );

endmodule

`default_nettype wire

// File: design/lkt_checker.sv
`default_nettype none

module lkt_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic [lkt_pkg::MODE_W-1:0]     mode,
    input wire logic [lkt_pkg::KEY_W-1:0]      group_id,
    input wire logic [lkt_pkg::KEY_W-1:0]      name_id,
    input wire logic [lkt_pkg::VALUE_W-1:0]    value_in,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic                           hit,
    input wire logic [lkt_pkg::VALUE_W-1:0]    value_out,
    input wire logic [lkt_pkg::OUTC_W-1:0]     entry_count,
    input wire logic                           evicted
);
    import lkt_pkg::*;

    // Waiting input holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(group_id)
            && $stable(name_id) && $stable(value_in))
        else $error("input changed while waiting");

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(value_out)
            && $stable(entry_count) && $stable(evicted))
        else $error("result changed while stalled");

    // A miss reports a zero value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> value_out == '0)
        else $error("nonzero value on miss");

    // A lookup hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit and evicted together");

    // Count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(entry_count) <= ENTRIES)
        else $error("entry count above table size");

endmodule

bind lru_keyed_table_with_group_invalidate lkt_checker u_lkt_checker (.*);

`default_nettype wire
